### design/fcer_pkg.sv
// fcer_pkg: shared types, constants and payload structs for the edge-replicating FIR unit.
// No dependencies; every other design file imports it.
`default_nettype none

package fcer_pkg;

  localparam int MAX_TAPS_DEF  = 7;
  localparam int COEF_FRAC_DEF = 14;

  localparam int NUM_COEF   = 7;
  localparam int SMP_W      = 16;
  localparam int PROD_W     = 2 * SMP_W;
  localparam int ACC_W      = PROD_W + $clog2(NUM_COEF);
  localparam int TAPS_W     = 3;
  localparam int CTR_W      = TAPS_W - 1;
  localparam int FILL_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [FILL_W-1:0]    FILL_MAX   = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_0 = 3'd1;
  localparam logic [TAPS_W-1:0]    TAPS_RESET = 3'd1;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef smp_t [NUM_COEF-1:0] coef_arr_t;

  localparam smp_t COEF0_RESET = 16'sd16384;

  typedef struct packed {
    smp_t sample;
    logic sample_last;
  } fcer_in_t;

  typedef struct packed {
    smp_t out_sample;
    logic out_last;
  } fcer_out_t;

  typedef struct packed {
    logic [TAPS_W-1:0] taps;
    coef_arr_t         coef;
  } fcer_cfg_t;

  // one filter evaluation: window values lined up with the taps
  typedef struct packed {
    coef_arr_t opnd;
    logic      last;
  } fcer_beat_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic                    last;
  } fcer_acc_t;

endpackage

`default_nettype wire

### design/fir_convolve_edge_replicate_unit.sv
// Centred FIR filter of up to seven taps over a finite sample series with replicated edges.
// Throughput is one sample per clock inside a series while the output is not stalled; the
// sample marked last holds the input while the flush sequencer in the window stage issues
// the trailing outputs one per cycle when not stalled. An accepted sample passes the
// window/sequencer register, then the tap products, sum, and round and saturate registers.
// Results lag the inputs by T/2 samples (T = taps in use); the final result of a series
// carries out_last. Write the configuration only while the block is idle.
`default_nettype none

module fir_convolve_edge_replicate_unit #(
  parameter int MAX_TAPS       = fcer_pkg::MAX_TAPS_DEF,
  parameter int COEF_FRAC_BITS = fcer_pkg::COEF_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fcer_pkg::fcer_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fcer_pkg::fcer_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fcer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcer_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fcer_pkg::*;

  fcer_cfg_t  cfg;
  logic       beat_valid, beat_ready;
  fcer_beat_t beat;
  logic       acc_valid, acc_ready;
  fcer_acc_t  acc;

  fcer_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fcer_window #(
    .MAX_TAPS (MAX_TAPS)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .taps       (cfg.taps),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .beat       (beat)
  );

  fcer_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef       (cfg.coef),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .beat       (beat),
    .acc_valid  (acc_valid),
    .acc_ready  (acc_ready),
    .acc        (acc)
  );

  fcer_out #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_valid (acc_valid),
    .acc_ready (acc_ready),
    .acc       (acc),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### design/fcer_cfg.sv
// fcer_cfg: configuration register file (tap count and seven Q2.14 coefficients).
// Depends on fcer_pkg.
`default_nettype none

module fcer_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fcer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcer_pkg::CFG_DATA_W-1:0]  cfg_data,
  output fcer_pkg::fcer_cfg_t              cfg
);
  import fcer_pkg::*;

  logic [TAPS_W-1:0] taps_r;
  coef_arr_t         coef_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= TAPS_RESET;
      coef_r <= {{(NUM_COEF-1){SMP_W'(0)}}, COEF0_RESET};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TAPS: taps_r <= cfg_data[TAPS_W-1:0];
        default: coef_r[CFG_IDX_W'(cfg_index - CFG_COEF_0)] <= smp_t'(cfg_data);
      endcase
    end
  end

  assign cfg.taps = taps_r;
  assign cfg.coef = coef_r;

endmodule

`default_nettype wire

### design/fcer_window.sv
// fcer_window: sample window with edge replication, fill tracking and the end-of-series
// flush sequencer that issues one filter evaluation per beat. Depends on fcer_pkg.
`default_nettype none

module fcer_window #(
  parameter int MAX_TAPS = fcer_pkg::MAX_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fcer_pkg::TAPS_W-1:0]   taps,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fcer_pkg::fcer_in_t            in_data,
  output logic                          beat_valid,
  input  logic                          beat_ready,
  output fcer_pkg::fcer_beat_t          beat
);
  import fcer_pkg::*;

  smp_t [MAX_TAPS-1:0] win_r, win_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                job_v_r, job_v_nxt;
  logic [CTR_W-1:0]    job_f_r, job_f_nxt;
  logic [CTR_W-1:0]    job_fmax_r, job_fmax_nxt;
  logic                job_last_r, job_last_nxt;
  logic [FILL_W-1:0]   job_seen_r, job_seen_nxt;

  logic [TAPS_W-1:0]   teff;
  logic [CTR_W-1:0]    ctap;
  logic                emit, adv, done, in_fire;

  // effective tap count: zero reads as one, clipped to the window depth and the coefficient count
  always_comb begin
    teff = taps;
    if (teff == '0) teff = TAPS_W'(1);
    if (int'(teff) > MAX_TAPS) teff = TAPS_W'(MAX_TAPS);
    if (int'(teff) > NUM_COEF) teff = TAPS_W'(NUM_COEF);
  end

  assign ctap = teff[TAPS_W-1:1];

  // a position before the centre has no output yet
  assign emit = job_v_r &&
                (({1'b0, job_seen_r} + {2'b00, job_f_r}) >= {2'b00, ctap});
  assign adv      = job_v_r && (!emit || beat_ready);
  assign done     = adv && (job_f_r == job_fmax_r);
  assign in_ready = !job_v_r || done;
  assign in_fire  = in_valid && in_ready;

  assign beat_valid = emit;

  always_comb begin
    logic signed [4:0] idx;
    idx = '0;
    beat.last = job_last_r && (job_f_r == job_fmax_r);
    for (int j = 0; j < NUM_COEF; j++) begin
      beat.opnd[j] = '0;
      if (j < int'(teff)) begin
        idx = $signed({2'b00, ctap, 1'b0}) - $signed(5'(j)) - $signed({3'b000, job_f_r});
        // clamp past the end to the newest sample
        if (idx < 0) idx = '0;
        for (int m = 0; m < MAX_TAPS; m++) begin
          if (idx == $signed(5'(m))) beat.opnd[j] = win_r[m];
        end
      end
    end
  end

  always_comb begin
    win_nxt      = win_r;
    fill_nxt     = fill_r;
    job_v_nxt    = job_v_r;
    job_f_nxt    = job_f_r;
    job_fmax_nxt = job_fmax_r;
    job_last_nxt = job_last_r;
    job_seen_nxt = job_seen_r;
    if (adv) begin
      job_f_nxt = job_f_r + CTR_W'(1);
    end
    if (done) begin
      job_v_nxt = 1'b0;
    end
    if (in_fire) begin
      if (fill_r == '0) begin
        // first sample of a series fills the whole window
        for (int m = 0; m < MAX_TAPS; m++) win_nxt[m] = in_data.sample;
      end else begin
        for (int m = MAX_TAPS - 1; m > 0; m--) win_nxt[m] = win_r[m-1];
        win_nxt[0] = in_data.sample;
      end
      if (in_data.sample_last) begin
        fill_nxt = '0;
      end else if (fill_r != FILL_MAX) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
      job_v_nxt    = 1'b1;
      job_f_nxt    = '0;
      job_fmax_nxt = in_data.sample_last ? ctap : '0;
      job_last_nxt = in_data.sample_last;
      job_seen_nxt = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      fill_r     <= '0;
      job_v_r    <= 1'b0;
      job_f_r    <= '0;
      job_fmax_r <= '0;
      job_last_r <= 1'b0;
      job_seen_r <= '0;
    end else begin
      win_r      <= win_nxt;
      fill_r     <= fill_nxt;
      job_v_r    <= job_v_nxt;
      job_f_r    <= job_f_nxt;
      job_fmax_r <= job_fmax_nxt;
      job_last_r <= job_last_nxt;
      job_seen_r <= job_seen_nxt;
    end
  end

  a_last_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.sample_last |=> fill_r == '0)
    else $error("fill count not cleared after end of series");

  a_flush_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    job_v_r |-> job_f_r <= job_fmax_r)
    else $error("flush position ran past its end");

  a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(win_r))
    else $error("window changed without an accepted sample");

endmodule

`default_nettype wire

### design/fcer_mac.sv
// fcer_mac: registered tap products and registered sum of products.
// Depends on fcer_pkg.
`default_nettype none

module fcer_mac (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fcer_pkg::coef_arr_t    coef,
  input  logic                   beat_valid,
  output logic                   beat_ready,
  input  fcer_pkg::fcer_beat_t   beat,
  output logic                   acc_valid,
  input  logic                   acc_ready,
  output fcer_pkg::fcer_acc_t    acc
);
  import fcer_pkg::*;

  logic                     s1_v_r, s1_v_nxt;
  logic                     s1_last_r;
  logic signed [PROD_W-1:0] prod_r [NUM_COEF];
  logic                     s2_v_r, s2_v_nxt;
  fcer_acc_t                s2_r;
  fcer_acc_t                sum_nxt;
  logic                     s1_ready, s2_ready;

  assign s2_ready   = !s2_v_r || acc_ready;
  assign s1_ready   = !s1_v_r || s2_ready;
  assign beat_ready = s1_ready;

  assign s1_v_nxt = s1_ready ? beat_valid : s1_v_r;
  assign s2_v_nxt = s2_ready ? s1_v_r : s2_v_r;

  always_comb begin
    sum_nxt.acc  = '0;
    sum_nxt.last = s1_last_r;
    for (int j = 0; j < NUM_COEF; j++) begin
      sum_nxt.acc = sum_nxt.acc + ACC_W'(prod_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_valid && s1_ready) begin
      s1_last_r <= beat.last;
      for (int j = 0; j < NUM_COEF; j++) begin
        prod_r[j] <= $signed(beat.opnd[j]) * $signed(coef[j]);
      end
    end
    if (s1_v_r && s2_ready) begin
      s2_r <= sum_nxt;
    end
  end

  assign acc_valid = s2_v_r;
  assign acc       = s2_r;

endmodule

`default_nettype wire

### design/fcer_out.sv
// fcer_out: round-half-up from the coefficient fraction, saturate to 16 bits, output register.
// Depends on fcer_pkg.
`default_nettype none

module fcer_out #(
  parameter int COEF_FRAC_BITS = fcer_pkg::COEF_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc_valid,
  output logic                  acc_ready,
  input  fcer_pkg::fcer_acc_t   acc,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fcer_pkg::fcer_out_t   out_data
);
  import fcer_pkg::*;

  localparam int RW = ACC_W + 1;
  localparam logic signed [RW-1:0] HALF   = RW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
  localparam logic signed [RW-1:0] SAT_LO = -RW'(32768);

  logic                 out_valid_r, out_valid_nxt;
  fcer_out_t            out_r, out_nxt;
  logic signed [RW-1:0] rnd, shf;

  assign acc_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = acc_ready ? acc_valid : out_valid_r;

  always_comb begin
    rnd = $signed({acc.acc[ACC_W-1], acc.acc}) + HALF;
    shf = rnd >>> COEF_FRAC_BITS;
    if (shf > SAT_HI) begin
      out_nxt.out_sample = 16'sh7FFF;
    end else if (shf < SAT_LO) begin
      out_nxt.out_sample = 16'sh8000;
    end else begin
      out_nxt.out_sample = shf[SMP_W-1:0];
    end
    out_nxt.out_last = acc.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_valid && acc_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
